// File: src/growth_model_euler_step_defines.svh
// Assertion macros for the RTL of the growth model block.
`ifndef GROWTH_MODEL_EULER_STEP_DEFINES_SVH
`define GROWTH_MODEL_EULER_STEP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GMES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GMES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/gmes_pkg.sv
package gmes_pkg;

    // Fraction bits of the logarithm and of the exponent in the power unit.
    localparam int POW_TABLE_BITS = 8;
    localparam int EXP_W = $clog2(POW_TABLE_BITS);
    localparam int LG_W = POW_TABLE_BITS + 6;

    localparam logic [31:0] Q_MAX_BITS = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN_BITS = 32'h8000_0000;
    localparam logic [30:0] Q_ONE_BITS = 31'd65536;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_GROWTH_RATE   = 3'd0;
    localparam logic [2:0] REG_REMOVAL_RATE  = 3'd1;
    localparam logic [2:0] REG_TIME_STEP     = 3'd2;
    localparam logic [2:0] REG_EXPONENT      = 3'd3;
    localparam logic [2:0] REG_CAPACITY      = 3'd4;
    localparam logic [2:0] REG_START_TOTAL   = 3'd5;
    localparam logic [2:0] REG_START_REMOVED = 3'd6;
    localparam logic [2:0] REG_START_ACTIVE  = 3'd7;

    typedef logic [30:0] fac_table_t [POW_TABLE_BITS];

    // Floored integer square root, evaluated only at elaboration.
    function automatic logic [63:0] isqrt_const(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Q30 factors 2^(2^-j), indexed by the fraction bit that selects them.
    function automatic fac_table_t build_fac_table();
        fac_table_t tab;
        logic [63:0] fac;
        fac = 64'h8000_0000;
        for (int j = 1; j <= POW_TABLE_BITS; j++)
        begin
            fac = isqrt_const(fac << 30);
            tab[POW_TABLE_BITS - j] = fac[30:0];
        end
        return tab;
    endfunction

    localparam fac_table_t FAC_TABLE = build_fac_table();

endpackage

// File: src/growth_model_euler_step.sv
// Sequence: a hold transaction goes straight to the result load; a step runs the
// bit-serial divide, the ratio and power checks, normalization, the squarings, the
// power setup, a multiply for each set exp2 fraction bit, then products, sums and load;
// a zero base or exponent skips the power stages. The load waits while a result is unclaimed.
// One transaction at a time on one 33x33 multiplier; the result register
// frees the input. Reset (rst_n low, asynchronous) loads register reset values.
module growth_model_euler_step
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        hold,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] total_out,
    output logic [31:0] removed_out,
    output logic [30:0] active_out,
    output logic        saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gmes_pkg::*;
    `include "growth_model_euler_step_defines.svh"

    // Sequencer states. The power unit and the five scaled products share
    // the one multiplier and its product register; the divide uses none.
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DIV     = 5'd1;
    localparam logic [4:0] S_RATIO   = 5'd2;
    localparam logic [4:0] S_POW_CHK = 5'd3;
    localparam logic [4:0] S_NORM    = 5'd4;
    localparam logic [4:0] S_SQ_MUL  = 5'd5;
    localparam logic [4:0] S_SQ_UPD  = 5'd6;
    localparam logic [4:0] S_LG_MUL  = 5'd7;
    localparam logic [4:0] S_EXP_SET = 5'd8;
    localparam logic [4:0] S_EXP_MUL = 5'd9;
    localparam logic [4:0] S_EXP_UPD = 5'd10;
    localparam logic [4:0] S_POW_FIN = 5'd11;
    localparam logic [4:0] S_M1      = 5'd12;
    localparam logic [4:0] S_C1      = 5'd13;
    localparam logic [4:0] S_M2      = 5'd14;
    localparam logic [4:0] S_C2      = 5'd15;
    localparam logic [4:0] S_M3      = 5'd16;
    localparam logic [4:0] S_C3      = 5'd17;
    localparam logic [4:0] S_M4      = 5'd18;
    localparam logic [4:0] S_C4      = 5'd19;
    localparam logic [4:0] S_M5      = 5'd20;
    localparam logic [4:0] S_C5      = 5'd21;
    localparam logic [4:0] S_DIFF    = 5'd22;
    localparam logic [4:0] S_FIN     = 5'd23;

    // Configuration registers.
    logic [31:0] growth_rate_reg;
    logic [31:0] removal_rate_reg;
    logic [30:0] time_step_reg;
    logic [30:0] exponent_reg;
    logic [30:0] capacity_reg;
    logic [31:0] start_total_reg;
    logic [31:0] start_removed_reg;
    logic [30:0] start_active_reg;

    // Model state; it doubles as the result register.
    logic [31:0] total_reg, total_next;
    logic [31:0] removed_reg, removed_next;
    logic [30:0] active_reg, active_next;
    logic        sat_reg, sat_next;
    logic        out_valid_reg, out_valid_next;
    logic [4:0]  state_reg, state_next;

    // Working registers of the sequencer.
    logic [5:0]                cnt_reg, cnt_next;
    logic                      neg_reg, neg_next;
    logic [47:0]               num_reg, num_next;
    logic [30:0]               rem_reg, rem_next;
    logic [30:0]               ratio_reg, ratio_next;
    logic [30:0]               norm_reg, norm_next;
    logic [4:0]                p_reg, p_next;
    logic [POW_TABLE_BITS-1:0] fb_reg, fb_next;
    logic signed [6:0]         ip_reg, ip_next;
    logic [POW_TABLE_BITS-1:0] fr_reg, fr_next;
    logic [30:0]               mant_reg, mant_next;
    logic [30:0]               pw_reg, pw_next;
    logic [31:0]               t_reg, t_next;
    logic [31:0]               nt_reg, nt_next;
    logic [31:0]               nr_reg, nr_next;
    logic [30:0]               na_reg, na_next;
    logic                      flag_reg, flag_next;
    logic signed [65:0]        prod_reg;

    // Combinational helpers.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [30:0]        cap_eff;
    logic [31:0]        div_rs;
    logic               div_ge;
    logic [31:0]        total_mag;
    logic signed [50:0] quot_s;
    logic signed [50:0] ratio_s;
    logic signed [65:0] prod_sh;
    logic [31:0]        cp_val;
    logic               cp_clip;
    logic signed [32:0] sum_s;
    logic signed [32:0] diff_s;
    logic [31:0]        m_sq;
    logic signed [LG_W-1:0] lg_s;
    logic [5:0]         p_m16;
    logic signed [65:0] ip_full;
    logic [6:0]         exp_shift;
    logic [EXP_W-1:0]   bit_idx;
    logic               accept_in;
    logic               load_out;
    logic               cfg_wr;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept_in   = in_valid && in_ready;
    assign load_out    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign total_out   = total_reg;
    assign removed_out = removed_reg;
    assign active_out  = active_reg;
    assign saturated   = sat_reg;

    // APB-style register file. Writes complete in the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            growth_rate_reg   <= '0;
            removal_rate_reg  <= '0;
            time_step_reg     <= 31'd6554;
            exponent_reg      <= 31'd65536;
            capacity_reg      <= 31'h7FFF_FFFF;
            start_total_reg   <= '0;
            start_removed_reg <= '0;
            start_active_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_GROWTH_RATE:   growth_rate_reg   <= pwdata;
                REG_REMOVAL_RATE:  removal_rate_reg  <= pwdata;
                REG_TIME_STEP:     time_step_reg     <= pwdata[30:0];
                REG_EXPONENT:      exponent_reg      <= pwdata[30:0];
                REG_CAPACITY:      capacity_reg      <= pwdata[30:0];
                REG_START_TOTAL:   start_total_reg   <= pwdata;
                REG_START_REMOVED: start_removed_reg <= pwdata;
                REG_START_ACTIVE:  start_active_reg  <= pwdata[30:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_GROWTH_RATE:   prdata = growth_rate_reg;
            REG_REMOVAL_RATE:  prdata = removal_rate_reg;
            REG_TIME_STEP:     prdata = {1'b0, time_step_reg};
            REG_EXPONENT:      prdata = {1'b0, exponent_reg};
            REG_CAPACITY:      prdata = {1'b0, capacity_reg};
            REG_START_TOTAL:   prdata = start_total_reg;
            REG_START_REMOVED: prdata = start_removed_reg;
            REG_START_ACTIVE:  prdata = {1'b0, start_active_reg};
            default:           prdata = '0;
        endcase
    end

    // Restoring divider step: one quotient bit of |total|*2^16 / capacity.
    // A zero capacity divides by one raw unit.
    assign cap_eff   = (capacity_reg == '0) ? 31'd1 : capacity_reg;
    assign div_rs    = {rem_reg, num_reg[47]};
    assign div_ge    = (div_rs >= {1'b0, cap_eff});
    assign total_mag = total_reg[31] ? 32'(-total_reg) : total_reg;

    // Floored signed quotient and the logistic factor 1 - total/capacity.
    assign quot_s  = neg_reg
                   ? -$signed({3'b000, num_reg}) - $signed({50'd0, (rem_reg != '0)})
                   : $signed({3'b000, num_reg});
    assign ratio_s = 51'sd65536 - quot_s;

    // Q16.16 view of the product register, floored and clamped.
    assign prod_sh = prod_reg >>> 16;
    always_comb
    begin
        cp_clip = 1'b1;
        if (prod_sh > 66'sd2147483647)
        begin
            cp_val = Q_MAX_BITS;
        end
        else if (prod_sh < -66'sd2147483648)
        begin
            cp_val = Q_MIN_BITS;
        end
        else
        begin
            cp_val  = prod_sh[31:0];
            cp_clip = 1'b0;
        end
    end

    // Power unit pieces: squared mantissa, log2 in fixed point, exp2 index.
    assign m_sq      = prod_reg[61:30];
    assign p_m16     = 6'({1'b0, p_reg}) - 6'd16;
    assign lg_s      = $signed({p_m16, fb_reg});
    assign ip_full   = prod_sh >>> POW_TABLE_BITS;
    assign exp_shift = 7'(7'sd14 - ip_reg);
    assign bit_idx   = cnt_reg[EXP_W-1:0];

    // Running sums for the two accumulated totals and the active difference.
    assign sum_s  = (state_reg == S_C3)
                  ? $signed({total_reg[31], total_reg}) + $signed({cp_val[31], cp_val})
                  : $signed({removed_reg[31], removed_reg}) + $signed({cp_val[31], cp_val});
    assign diff_s = $signed({nt_reg[31], nt_reg}) - $signed({nr_reg[31], nr_reg});

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ_MUL:
            begin
                mul_a = $signed({2'b00, norm_reg});
                mul_b = $signed({2'b00, norm_reg});
            end
            S_LG_MUL:
            begin
                mul_a = $signed({{(33 - LG_W){lg_s[LG_W-1]}}, lg_s});
                mul_b = $signed({2'b00, exponent_reg});
            end
            S_EXP_MUL:
            begin
                mul_a = $signed({2'b00, mant_reg});
                mul_b = $signed({2'b00, FAC_TABLE[bit_idx]});
            end
            S_M1:
            begin
                mul_a = $signed({growth_rate_reg[31], growth_rate_reg});
                mul_b = $signed({2'b00, pw_reg});
            end
            S_M2:
            begin
                mul_a = $signed({t_reg[31], t_reg});
                mul_b = $signed({2'b00, ratio_reg});
            end
            S_M3, S_M5:
            begin
                mul_a = $signed({t_reg[31], t_reg});
                mul_b = $signed({2'b00, time_step_reg});
            end
            S_M4:
            begin
                mul_a = $signed({removal_rate_reg[31], removal_rate_reg});
                mul_b = $signed({2'b00, active_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        ratio_next     = ratio_reg;
        norm_next      = norm_reg;
        p_next         = p_reg;
        fb_next        = fb_reg;
        ip_next        = ip_reg;
        fr_next        = fr_reg;
        mant_next      = mant_reg;
        pw_next        = pw_reg;
        t_next         = t_reg;
        nt_next        = nt_reg;
        nr_next        = nr_reg;
        na_next        = na_reg;
        flag_next      = flag_reg;
        total_next     = total_reg;
        removed_next   = removed_reg;
        active_next    = active_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    flag_next = 1'b0;
                    if (hold)
                    begin
                        nt_next    = start_total_reg;
                        nr_next    = start_removed_reg;
                        na_next    = start_active_reg;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        neg_next   = total_reg[31];
                        num_next   = {total_mag, 16'd0};
                        rem_next   = '0;
                        cnt_next   = 6'd48;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = div_ge ? 31'(div_rs - {1'b0, cap_eff}) : div_rs[30:0];
                num_next = {num_reg[46:0], div_ge};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    state_next = S_RATIO;
                end
            end
            S_RATIO:
            begin
                // Negative ratios are the max(0, .) of the model: no flag.
                if (ratio_s < 0)
                begin
                    ratio_next = '0;
                end
                else if (ratio_s > 51'sd2147483647)
                begin
                    ratio_next = Q_MAX_BITS[30:0];
                    flag_next  = 1'b1;
                end
                else
                begin
                    ratio_next = ratio_s[30:0];
                end
                state_next = S_POW_CHK;
            end
            S_POW_CHK:
            begin
                if (active_reg == '0)
                begin
                    pw_next    = (exponent_reg != '0) ? 31'd0 : Q_ONE_BITS;
                    state_next = S_M1;
                end
                else if (exponent_reg == '0)
                begin
                    pw_next    = Q_ONE_BITS;
                    state_next = S_M1;
                end
                else
                begin
                    norm_next  = active_reg;
                    p_next     = 5'd30;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // One bit a cycle until the leading one sits at bit 30.
                if (norm_reg[30])
                begin
                    fb_next    = '0;
                    cnt_next   = '0;
                    state_next = S_SQ_MUL;
                end
                else
                begin
                    norm_next = {norm_reg[29:0], 1'b0};
                    p_next    = p_reg - 5'd1;
                end
            end
            S_SQ_MUL:
            begin
                state_next = S_SQ_UPD;
            end
            S_SQ_UPD:
            begin
                if (m_sq[31])
                begin
                    norm_next = m_sq[31:1];
                    fb_next   = {fb_reg[POW_TABLE_BITS-2:0], 1'b1};
                end
                else
                begin
                    norm_next = m_sq[30:0];
                    fb_next   = {fb_reg[POW_TABLE_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(POW_TABLE_BITS - 1))
                begin
                    state_next = S_LG_MUL;
                end
                else
                begin
                    state_next = S_SQ_MUL;
                end
            end
            S_LG_MUL:
            begin
                state_next = S_EXP_SET;
            end
            S_EXP_SET:
            begin
                if (ip_full >= 66'sd15)
                begin
                    pw_next    = Q_MAX_BITS[30:0];
                    flag_next  = 1'b1;
                    state_next = S_M1;
                end
                else if (ip_full <= -66'sd49)
                begin
                    pw_next    = '0;
                    state_next = S_M1;
                end
                else
                begin
                    ip_next    = ip_full[6:0];
                    fr_next    = prod_sh[POW_TABLE_BITS-1:0];
                    mant_next  = 31'h4000_0000;
                    cnt_next   = 6'(POW_TABLE_BITS - 1);
                    state_next = S_EXP_MUL;
                end
            end
            S_EXP_MUL:
            begin
                // Fraction bits are taken from the top; a clear bit skips the multiply update.
                if (fr_reg[bit_idx])
                begin
                    state_next = S_EXP_UPD;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_POW_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 6'd1;
                end
            end
            S_EXP_UPD:
            begin
                mant_next = prod_reg[60:30];
                if (cnt_reg == '0)
                begin
                    state_next = S_POW_FIN;
                end
                else
                begin
                    cnt_next   = cnt_reg - 6'd1;
                    state_next = S_EXP_MUL;
                end
            end
            S_POW_FIN:
            begin
                if (ip_reg >= 7'sd14)
                begin
                    pw_next = mant_reg;
                end
                else
                begin
                    pw_next = mant_reg >> exp_shift;
                end
                state_next = S_M1;
            end
            S_M1, S_M2, S_M3, S_M4, S_M5:
            begin
                state_next = 5'(state_reg + 5'd1);
            end
            S_C1, S_C2, S_C4:
            begin
                t_next     = cp_val;
                flag_next  = flag_reg | cp_clip;
                state_next = 5'(state_reg + 5'd1);
            end
            S_C3, S_C5:
            begin
                flag_next = flag_reg | cp_clip;
                if (sum_s[32] != sum_s[31])
                begin
                    flag_next = 1'b1;
                    if (state_reg == S_C3)
                    begin
                        nt_next = sum_s[32] ? Q_MIN_BITS : Q_MAX_BITS;
                    end
                    else
                    begin
                        nr_next = sum_s[32] ? Q_MIN_BITS : Q_MAX_BITS;
                    end
                end
                else if (state_reg == S_C3)
                begin
                    nt_next = sum_s[31:0];
                end
                else
                begin
                    nr_next = sum_s[31:0];
                end
                state_next = (state_reg == S_C3) ? S_M4 : S_DIFF;
            end
            S_DIFF:
            begin
                if (diff_s < 0)
                begin
                    na_next = '0;
                end
                else if (diff_s[31])
                begin
                    na_next   = Q_MAX_BITS[30:0];
                    flag_next = 1'b1;
                end
                else
                begin
                    na_next = diff_s[30:0];
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Waits only while an earlier result is still unclaimed.
                if (load_out)
                begin
                    total_next     = nt_reg;
                    removed_next   = nr_reg;
                    active_next    = na_reg;
                    sat_next       = flag_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
            removed_reg   <= '0;
            active_reg    <= '0;
            sat_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            removed_reg   <= removed_next;
            active_reg    <= active_next;
            sat_reg       <= sat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        ratio_reg <= ratio_next;
        norm_reg  <= norm_next;
        p_reg     <= p_next;
        fb_reg    <= fb_next;
        ip_reg    <= ip_next;
        fr_reg    <= fr_next;
        mant_reg  <= mant_next;
        pw_reg    <= pw_next;
        t_reg     <= t_next;
        nt_reg    <= nt_next;
        nr_reg    <= nr_next;
        na_reg    <= na_next;
        flag_reg  <= flag_next;
        prod_reg  <= mul_a * mul_b;
    end

    `GMES_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept_in, state_reg != S_IDLE, "accepted transaction did not start the sequencer")
    `GMES_ASSERT_NEXT(a_hold_short_path, clk, rst_n, accept_in && hold, state_reg == S_FIN, "hold transaction left the short path")
    `GMES_ASSERT_NEXT(a_result_not_overwritten, clk, rst_n, (state_reg == S_FIN) && out_valid_reg && !out_ready, (state_reg == S_FIN) && out_valid_reg, "pending result overwritten")
    `GMES_ASSERT_IMPL(a_no_load_while_busy, clk, rst_n, load_out, !in_ready, "result loaded while sequencer idle")

endmodule
